/* rtl/tgad_pkg.sv */
// shared types and constants for the tga truecolor stream decoder
package tgad_pkg;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_HEADER = 2'd1,
		PH_IDSKIP = 2'd2,
		PH_PIXELS = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_PIXEL  = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_FORMAT       = 2'd0,
		ERR_SHORT_HEADER = 2'd1,
		ERR_SHORT_PIXELS = 2'd2
	} err_t;

	localparam logic [7:0] TGA_TYPE_TRUECOLOR = 8'd2;
	localparam logic [7:0] DEPTH_RGB          = 8'd24;
	localparam logic [7:0] DEPTH_RGBA         = 8'd32;
	localparam int         ORIGIN_TOP_BIT     = 5;
	localparam logic [7:0] ALPHA_OPAQUE       = 8'hFF;

	// one classified beat handed from the parser to the output side
	typedef struct packed {
		kind_t       kind;
		err_t        err_code;
		logic [15:0] width;
		logic [15:0] height;
		logic [5:0]  bpp;
		logic [15:0] row;
		logic [15:0] col;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic        last_px;
	} entry_t;

	// master tdata layout, last member sits in the lowest bits
	typedef struct packed {
		logic [7:0]  alpha;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [31:0] pixel_offset;
		logic [5:0]  bits_per_pixel;
		logic [15:0] image_height;
		logic [15:0] image_width;
		logic [1:0]  error_code;
	} out_data_t;

endpackage

/* rtl/tga_truecolor_stream_decoder.sv */
// top level of the tga truecolor stream decoder
// Input stream: one file byte per beat on s_tdata, s_tuser marks the first
// byte of a file (restarts parsing), s_tlast marks its final byte.
// Output stream: one result per beat; m_tuser is the kind (header, pixel,
// error), m_tlast flags the final pixel of the image, m_tdata carries the
// header values, pixel address and RGBA channels.
// A byte is taken every cycle while the entry queue has room; the sustained
// rate is one byte per cycle; a 24-bit pixel takes three bytes and a
// 32-bit pixel four. A result goes from the byte that causes it through the
// entry queue, a stage register for the queue read and the row times width
// multiply, and the output register that does the address add.
// When the receiver stalls, results back up into the queue of QUEUE_DEPTH
// entries; once it is full s_tready drops until the receiver takes a beat.
// Reset clears the parser to idle and empties the queue; bytes before the
// next beat with s_tuser set are dropped, as are bytes after an error or
// after the final pixel.
module tga_truecolor_stream_decoder import tgad_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // data_byte
	input  logic         s_tuser,   // first
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// error_code, image_width, image_height, bits_per_pixel, pixel_offset,
	// red, green, blue, alpha
	output logic [103:0] m_tdata,
	output logic [1:0]   m_tuser,   // result_kind
	output logic         m_tlast
);

	localparam int ENTRY_W = $bits(entry_t);

	logic             push, pop, full, empty;
	entry_t           wr_entry, rd_entry;
	logic [ENTRY_W-1:0] rd_bits;
	out_data_t        out_data;

	tgad_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.full     (full),
		.push     (push),
		.entry    (wr_entry)
	);

	tgad_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wr_entry),
		.full   (full),
		.pop    (pop),
		.rdata  (rd_bits),
		.empty  (empty)
	);

	assign rd_entry = entry_t'(rd_bits);

	tgad_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.rd_entry (rd_entry),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (out_data),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	assign m_tdata = out_data;

`ifndef ASSERT_OFF
	a_last_is_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == KIND_PIXEL)
		else $error("final pixel flag on a non-pixel beat");

	a_err_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_ERROR) |-> m_tdata[1:0] == ERR_FORMAT)
		else $error("error code set on a non-error beat");

	a_pixel_hdr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_PIXEL) |-> m_tdata[39:2] == '0)
		else $error("header fields not cleared on a pixel beat");
`endif

endmodule

/* rtl/tgad_front.sv */
// byte parser: header capture, id skip and pixel assembly into queue entries
module tgad_front import tgad_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        s_tlast,
	input  logic        full,
	output logic        push,
	output entry_t      entry
);

	localparam logic [4:0] IDX_ID_LEN   = 5'd0;
	localparam logic [4:0] IDX_TYPE     = 5'd2;
	localparam logic [4:0] IDX_WIDTH_LO = 5'd12;
	localparam logic [4:0] IDX_WIDTH_HI = 5'd13;
	localparam logic [4:0] IDX_HGT_LO   = 5'd14;
	localparam logic [4:0] IDX_HGT_HI   = 5'd15;
	localparam logic [4:0] IDX_DEPTH    = 5'd16;
	localparam logic [4:0] IDX_DESC     = 5'd17;

	phase_t      phase_q, phase_nxt, eff_phase;
	logic [4:0]  idx_q, eff_idx;
	logic [7:0]  id_left_q;
	logic [7:0]  type_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [7:0]  depth_q;
	logic        origin_top_q;
	logic [1:0]  chan_q;
	logic [23:0] held_q;
	logic [15:0] col_q;
	logic [15:0] row_q;

	logic go, hdr_end, fmt_bad, img_empty, id_done, is32, px_done, px_final, col_wrap;
	logic [15:0] row_dst;

	assign s_tready  = !full;
	assign go        = s_tvalid && s_tready;
	assign eff_phase = s_tuser ? PH_HEADER : phase_q;
	assign eff_idx   = s_tuser ? 5'd0 : idx_q;
	assign hdr_end   = (eff_idx == IDX_DESC);
	assign fmt_bad   = (type_q != TGA_TYPE_TRUECOLOR) ||
		((depth_q != DEPTH_RGB) && (depth_q != DEPTH_RGBA));
	assign img_empty = (width_q == 16'd0) || (height_q == 16'd0);
	assign id_done   = (id_left_q == 8'd1);
	assign is32      = (depth_q == DEPTH_RGBA);
	assign px_done   = (chan_q == 2'd3) || ((chan_q == 2'd2) && !is32);
	assign px_final  = (({1'b0, col_q} + 17'd1) == {1'b0, width_q}) &&
		(({1'b0, row_q} + 17'd1) == {1'b0, height_q});
	assign col_wrap  = (({1'b0, col_q} + 17'd1) >= {1'b0, width_q});
	// bottom-left origin stores rows bottom up
	assign row_dst   = origin_top_q ? row_q : (height_q - 16'd1 - row_q);

	always_comb begin
		phase_nxt = phase_q;
		if (go) begin
			case (eff_phase)
				PH_HEADER: begin
					if (hdr_end) begin
						if (fmt_bad || img_empty || s_tlast)
							phase_nxt = PH_IDLE;
						else
							phase_nxt = (id_left_q != 8'd0) ? PH_IDSKIP : PH_PIXELS;
					end else begin
						phase_nxt = s_tlast ? PH_IDLE : PH_HEADER;
					end
				end
				PH_IDSKIP: begin
					if (s_tlast)
						phase_nxt = PH_IDLE;
					else
						phase_nxt = id_done ? PH_PIXELS : PH_IDSKIP;
				end
				PH_PIXELS: begin
					if (s_tlast || (px_done && px_final))
						phase_nxt = PH_IDLE;
					else
						phase_nxt = PH_PIXELS;
				end
				default: phase_nxt = PH_IDLE;
			endcase
		end
	end

	always_comb begin
		push  = 1'b0;
		entry = '0;
		if (go) begin
			case (eff_phase)
				PH_HEADER: begin
					if (hdr_end) begin
						push = 1'b1;
						if (fmt_bad) begin
							entry.kind     = KIND_ERROR;
							entry.err_code = ERR_FORMAT;
						end else if (!img_empty && s_tlast) begin
							entry.kind     = KIND_ERROR;
							entry.err_code = ERR_SHORT_PIXELS;
						end else begin
							entry.kind   = KIND_HEADER;
							entry.width  = width_q;
							entry.height = height_q;
							entry.bpp    = depth_q[5:0];
						end
					end else if (s_tlast) begin
						push           = 1'b1;
						entry.kind     = KIND_ERROR;
						entry.err_code = ERR_SHORT_HEADER;
					end
				end
				PH_IDSKIP: begin
					if (s_tlast) begin
						push           = 1'b1;
						entry.kind     = KIND_ERROR;
						entry.err_code = ERR_SHORT_PIXELS;
					end
				end
				PH_PIXELS: begin
					if (s_tlast && !(px_done && px_final)) begin
						push           = 1'b1;
						entry.kind     = KIND_ERROR;
						entry.err_code = ERR_SHORT_PIXELS;
					end else if (px_done) begin
						push          = 1'b1;
						entry.kind    = KIND_PIXEL;
						entry.width   = width_q;
						entry.row     = row_dst;
						entry.col     = col_q;
						entry.red     = (chan_q == 2'd2) ? s_tdata : held_q[23:16];
						entry.green   = held_q[15:8];
						entry.blue    = held_q[7:0];
						entry.alpha   = (chan_q == 2'd3) ? s_tdata : ALPHA_OPAQUE;
						entry.last_px = px_final;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			idx_q        <= '0;
			id_left_q    <= '0;
			type_q       <= '0;
			width_q      <= '0;
			height_q     <= '0;
			depth_q      <= '0;
			origin_top_q <= 1'b0;
			chan_q       <= '0;
			held_q       <= '0;
			col_q        <= '0;
			row_q        <= '0;
		end else begin
			phase_q <= phase_nxt;
			if (go) begin
				if (s_tuser) begin
					chan_q <= '0;
					col_q  <= '0;
					row_q  <= '0;
				end
				case (eff_phase)
					PH_HEADER: begin
						idx_q <= eff_idx + 5'd1;
						case (eff_idx)
							IDX_ID_LEN:   id_left_q       <= s_tdata;
							IDX_TYPE:     type_q          <= s_tdata;
							IDX_WIDTH_LO: width_q[7:0]    <= s_tdata;
							IDX_WIDTH_HI: width_q[15:8]   <= s_tdata;
							IDX_HGT_LO:   height_q[7:0]   <= s_tdata;
							IDX_HGT_HI:   height_q[15:8]  <= s_tdata;
							IDX_DEPTH:    depth_q         <= s_tdata;
							IDX_DESC:     origin_top_q    <= s_tdata[ORIGIN_TOP_BIT];
							default: ;
						endcase
					end
					PH_IDSKIP: id_left_q <= id_left_q - 8'd1;
					PH_PIXELS: begin
						case (chan_q)
							2'd0:    held_q[7:0]   <= s_tdata;
							2'd1:    held_q[15:8]  <= s_tdata;
							2'd2:    held_q[23:16] <= s_tdata;
							default: ;
						endcase
						if (!px_done) begin
							chan_q <= chan_q + 2'd1;
						end else if (!(s_tlast && !px_final)) begin
							chan_q <= '0;
							if (col_wrap) begin
								col_q <= '0;
								row_q <= row_q + 16'd1;
							end else begin
								col_q <= col_q + 16'd1;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule

/* rtl/tgad_queue.sv */
// small register fifo between parser and output side
module tgad_queue import tgad_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

endmodule

/* rtl/tgad_back.sv */
// output side: pixel address multiply, field masking and output register
module tgad_back import tgad_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	input  entry_t      rd_entry,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output out_data_t   m_tdata,
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	logic        v_s1;
	entry_t      ent_s1;
	logic [31:0] prod_s1;
	logic [31:0] prod_c;
	logic        ready_s1, ready_s2;
	logic        is_hdr;

	assign ready_s2 = !m_tvalid || m_tready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign pop      = !empty && ready_s1;
	assign prod_c   = {16'd0, rd_entry.row} * {16'd0, rd_entry.width};
	assign is_hdr   = (ent_s1.kind == KIND_HEADER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (ready_s1)
				v_s1 <= pop;
			if (ready_s2)
				m_tvalid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_s1  <= rd_entry;
			prod_s1 <= prod_c;
		end
		if (ready_s2 && v_s1) begin
			m_tuser                <= ent_s1.kind;
			m_tlast                <= ent_s1.last_px;
			m_tdata.error_code     <= ent_s1.err_code;
			// pixel entries carry width only for the multiply
			m_tdata.image_width    <= is_hdr ? ent_s1.width : 16'd0;
			m_tdata.image_height   <= is_hdr ? ent_s1.height : 16'd0;
			m_tdata.bits_per_pixel <= is_hdr ? ent_s1.bpp : 6'd0;
			m_tdata.pixel_offset   <= prod_s1 + {16'd0, ent_s1.col};
			m_tdata.red            <= ent_s1.red;
			m_tdata.green          <= ent_s1.green;
			m_tdata.blue           <= ent_s1.blue;
			m_tdata.alpha          <= ent_s1.alpha;
		end
	end

endmodule
